/* rtl/tmes_pkg.sv */
// shared types, constants and helpers for the timestamped midi event scheduler
// no dependencies; used by tmes_out_buf and timestamped_midi_event_scheduler
`default_nettype none

package tmes_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  localparam logic [31:0] PastLimit  = 32'h8000_0000;
  localparam logic [2:0]  MaxBytes   = 3'd3;

  typedef enum logic [1:0] {
    KindAccept  = 2'd0,
    KindReject  = 2'd1,
    KindRelease = 2'd2,
    KindMarker  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StIdle,
    StPush,
    StRead,
    StCheck,
    StMark
  } state_e;

  typedef struct packed {
    logic        func;
    logic [31:0] time_offset;
    logic [7:0]  port;
    logic [7:0]  status_byte;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [2:0]  byte_count;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  event_port;
    logic [7:0]  event_status;
    logic [7:0]  event_data_one;
    logic [7:0]  event_data_two;
    logic [1:0]  event_length;
    logic        late;
    logic [31:0] sample_time;
    logic        last;
  } out_t;

  // one stored event, most significant field first
  typedef struct packed {
    logic [7:0]  data_two;
    logic [7:0]  data_one;
    logic [7:0]  status;
    logic [7:0]  port;
    logic [31:0] due_time;
  } entry_t;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] nxt;
    if (ptr == PtrW'(QueueDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + PtrW'(1);
    end
    return nxt;
  endfunction

  // message length from the status byte
  function automatic logic [1:0] msg_len(input logic [7:0] st);
    logic [1:0] len;
    case (st) inside
      [8'h80:8'hBF]:  len = 2'd3;
      [8'hC0:8'hDF]:  len = 2'd2;
      [8'hE0:8'hEF]:  len = 2'd3;
      8'hF1, 8'hF3:   len = 2'd2;
      8'hF2:          len = 2'd3;
      default:        len = 2'd1;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

/* rtl/tmes_out_buf.sv */
// single-entry output register for result transactions
// depends on tmes_pkg for the result struct
`default_nettype none

module tmes_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tmes_pkg::out_t push_data_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tmes_pkg::out_t     out_item_o
);

  logic           valid_q, valid_d;
  tmes_pkg::out_t data_q;

  // slot frees up in the same cycle the sink takes it
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i && free_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = data_q;

endmodule

`default_nettype wire

/* rtl/timestamped_midi_event_scheduler.sv */
// top level: fifo of timestamped midi events in one synchronous memory
// depends on tmes_pkg and tmes_out_buf
`default_nettype none

//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+------------------
//  input   | in_valid_i / in_ready_o        | sink      | tmes_pkg::in_t
//  output  | out_valid_o / out_ready_i      | source    | tmes_pkg::out_t
//
// a push is taken in the idle state, then the push state loads the result register
// and, for an accepted entry, writes the memory
// a tick reads and checks each front entry in turn, from the read state to the
// check state, until the queue is empty or an entry not yet due is left at the head
// reset clears pointers, count, sample time and state; the store is not cleared
// a stalled output holds the sequencer in place; input is taken only when idle

module timestamped_midi_event_scheduler (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tmes_pkg::in_t in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output tmes_pkg::out_t     out_item_o
);

  tmes_pkg::state_e state_q, state_d;
  tmes_pkg::in_t    item_q;

  logic [tmes_pkg::PtrW-1:0] rd_ptr_q, wr_ptr_q;
  logic [tmes_pkg::CntW-1:0] count_q;
  logic [31:0]               time_q;

  // event store, read data registered
  tmes_pkg::entry_t mem_q [tmes_pkg::QueueDepth];
  tmes_pkg::entry_t rdata_q;
  tmes_pkg::entry_t wr_entry;

  logic           in_fire;
  logic           slot_free;
  logic           res_valid;
  tmes_pkg::out_t res;
  logic           mem_we, rd_en;
  logic           rel_fire, mark_fire;
  logic           push_ok;
  logic           queue_empty;
  logic [31:0]    diff;
  logic           late, due;

  assign in_fire     = in_valid_i && in_ready_o;
  assign queue_empty = (count_q == '0);

  // length 1..3 and room left
  assign push_ok = (item_q.byte_count != 3'd0) && (item_q.byte_count <= tmes_pkg::MaxBytes)
                   && (count_q != tmes_pkg::CntW'(tmes_pkg::QueueDepth));

  // wrap-around due test on the front entry
  assign diff = rdata_q.due_time - time_q;
  assign late = diff > tmes_pkg::PastLimit;
  assign due  = (diff == '0) || late;

  // new entry: stamp with current time plus offset, zero unused bytes
  always_comb begin
    wr_entry          = '0;
    wr_entry.due_time = time_q + item_q.time_offset;
    wr_entry.port     = item_q.port;
    wr_entry.status   = item_q.status_byte;
    if (item_q.byte_count >= 3'd2) begin
      wr_entry.data_one = item_q.data_one;
    end
    if (item_q.byte_count >= 3'd3) begin
      wr_entry.data_two = item_q.data_two;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tmes_pkg::StIdle: begin
        if (in_fire) begin
          state_d = in_item_i.func ? tmes_pkg::StRead : tmes_pkg::StPush;
        end
      end
      tmes_pkg::StPush: begin
        if (slot_free) begin
          state_d = tmes_pkg::StIdle;
        end
      end
      tmes_pkg::StRead: begin
        state_d = queue_empty ? tmes_pkg::StMark : tmes_pkg::StCheck;
      end
      tmes_pkg::StCheck: begin
        if (!due) begin
          state_d = tmes_pkg::StMark;
        end else if (slot_free) begin
          state_d = tmes_pkg::StRead;
        end
      end
      tmes_pkg::StMark: begin
        if (slot_free) begin
          state_d = tmes_pkg::StIdle;
        end
      end
      default: state_d = tmes_pkg::StIdle;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o      = 1'b0;
    res_valid       = 1'b0;
    res             = '0;
    res.sample_time = time_q;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    rel_fire        = 1'b0;
    mark_fire       = 1'b0;
    case (state_q)
      tmes_pkg::StIdle: begin
        in_ready_o = 1'b1;
      end
      tmes_pkg::StPush: begin
        res_valid = 1'b1;
        res.kind  = push_ok ? tmes_pkg::KindAccept : tmes_pkg::KindReject;
        res.last  = 1'b1;
        mem_we    = slot_free && push_ok;
      end
      tmes_pkg::StRead: begin
        rd_en = !queue_empty;
      end
      tmes_pkg::StCheck: begin
        if (due) begin
          res_valid          = 1'b1;
          res.kind           = tmes_pkg::KindRelease;
          res.event_port     = rdata_q.port;
          res.event_status   = rdata_q.status;
          res.event_data_one = rdata_q.data_one;
          res.event_data_two = rdata_q.data_two;
          res.event_length   = tmes_pkg::msg_len(rdata_q.status);
          res.late           = late;
          rel_fire           = slot_free;
        end
      end
      tmes_pkg::StMark: begin
        res_valid = 1'b1;
        res.kind  = tmes_pkg::KindMarker;
        res.last  = 1'b1;
        mark_fire = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tmes_pkg::StIdle;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
      time_q   <= '0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        wr_ptr_q <= tmes_pkg::ptr_inc(wr_ptr_q);
        count_q  <= count_q + tmes_pkg::CntW'(1);
      end else if (rel_fire) begin
        rd_ptr_q <= tmes_pkg::ptr_inc(rd_ptr_q);
        count_q  <= count_q - tmes_pkg::CntW'(1);
      end
      if (mark_fire) begin
        time_q <= time_q + 32'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
  end

  // event store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= wr_entry;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  tmes_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .free_o      (slot_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

`ifndef ASSERT_OFF
  // occupancy never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= tmes_pkg::CntW'(tmes_pkg::QueueDepth))
    else $error("entry count beyond queue depth");

  // empty or full queue means the pointers meet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == tmes_pkg::CntW'(tmes_pkg::QueueDepth))
    |-> rd_ptr_q == wr_ptr_q)
    else $error("pointers disagree with entry count");

  // a release only comes from a non-empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_fire |-> !queue_empty)
    else $error("release from empty queue");

  // memory write and read never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && rd_en))
    else $error("store read and write overlap");

  // sample time moves only with a marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mark_fire |=> time_q == $past(time_q))
    else $error("sample time changed without marker");
`endif

endmodule

`default_nettype wire
